@@ src/b2d_pkg.sv @@
`default_nettype none
package b2d_pkg;

  localparam int VALUE_W         = 32;
  localparam int DIGIT_W         = 4;
  // decimal digits that a full-range input can need
  localparam int BCD_DIGITS      = 10;
  localparam int BCD_W           = BCD_DIGITS * DIGIT_W;
  localparam int CHAR_W          = 6;
  localparam int STEPS_PER_STAGE = 4;
  localparam int DABBLE_STAGES   = VALUE_W / STEPS_PER_STAGE;
  localparam int MAX_DIGITS_DEF  = 10;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO   = 6'd48;
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADJ   = 4'd3;

  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
  } dabble_t;

endpackage
`default_nettype wire

@@ src/b2d_if.sv @@
`default_nettype none
interface b2d_value_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface b2d_char_if;
  logic       valid;
  logic       ready;
  logic [5:0] digit_char;
  logic       last_char;

  modport source (output valid, output digit_char, output last_char, input ready);
  modport sink (input valid, input digit_char, input last_char, output ready);
endinterface
`default_nettype wire

@@ src/binary_to_decimal_ascii.sv @@
`default_nettype none
// channel | dir | payload                     | transfer when
// number  | in  | value[31:0]                 | valid && ready
// text    | out | digit_char[5:0], last_char  | valid && ready
//
// a number is converted by an 8-stage shift-and-add-3 pipeline (4 bits per stage),
// then a serializer sends one character per cycle while text is ready, most significant first
// each number goes out as one character per digit (1 to 10),
// a new number is loaded in the cycle its predecessor's last character enters the output register
// a number passes the stage registers, the serializer's digit store and its output register
// before its first character; reset clears all valid bits; a stall on text backs up through every stage
module binary_to_decimal_ascii #(
  parameter int MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF
) (
  input logic             clk,
  input logic             rst,
  b2d_value_if.sink       number,
  b2d_char_if.source      text
);
  import b2d_pkg::*;

  dabble_t                stg_data [DABBLE_STAGES+1];
  logic [DABBLE_STAGES:0] stg_valid;
  logic [DABBLE_STAGES:0] stg_ready;

  assign stg_valid[0] = number.valid;
  assign number.ready = stg_ready[0];
  assign stg_data[0]  = '{bcd: '0, bin: number.value};

  for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_stage
    b2d_dabble_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[g]),
      .in_ready  (stg_ready[g]),
      .in_data   (stg_data[g]),
      .out_valid (stg_valid[g+1]),
      .out_ready (stg_ready[g+1]),
      .out_data  (stg_data[g+1])
    );
  end

  b2d_serializer #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_ser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (stg_valid[DABBLE_STAGES]),
    .in_ready   (stg_ready[DABBLE_STAGES]),
    .bcd        (stg_data[DABBLE_STAGES].bcd),
    .out_valid  (text.valid),
    .out_ready  (text.ready),
    .digit_char (text.digit_char),
    .last_char  (text.last_char)
  );

endmodule
`default_nettype wire

@@ src/b2d_dabble_stage.sv @@
`default_nettype none
module b2d_dabble_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  b2d_pkg::dabble_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output b2d_pkg::dabble_t   out_data
);
  import b2d_pkg::*;

  localparam int DW = BCD_W + VALUE_W;

  logic [DW-1:0] work;
  dabble_t       data_next;

  // STEPS_PER_STAGE (4) shift-and-add-3 steps of the binary to bcd conversion
  always_comb begin
    work = in_data;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (work[VALUE_W + d*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT) begin
          work[VALUE_W + d*DIGIT_W +: DIGIT_W] =
            work[VALUE_W + d*DIGIT_W +: DIGIT_W] + DABBLE_ADJ;
        end
      end
      work = {work[DW-2:0], 1'b0};
    end
    data_next = work;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

@@ src/b2d_serializer.sv @@
`default_nettype none
module b2d_serializer #(
  parameter int MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [b2d_pkg::BCD_W-1:0]   bcd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [b2d_pkg::CHAR_W-1:0]  digit_char,
  output logic                        last_char
);
  import b2d_pkg::*;

  // only the low digits are shown; above the input's range they are zero anyway
  localparam int SHOWN = (MAX_DIGITS < BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;
  localparam int IDX_W = (SHOWN > 1) ? $clog2(SHOWN) : 1;

  logic               busy;
  logic [IDX_W-1:0]   idx;
  logic [DIGIT_W-1:0] dig [SHOWN];
  logic [IDX_W-1:0]   top_idx;
  logic               adv;
  logic               emit;
  logic               load;
  logic               at_last;

  // position of the leading nonzero digit, zero when all are zero
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < SHOWN; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  assign adv      = !out_valid || out_ready;
  assign emit     = busy && adv;
  assign at_last  = (idx == '0);
  assign in_ready = !busy || (emit && at_last);
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= busy;
      end
      if (load) begin
        busy <= 1'b1;
      end else if (emit && at_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      digit_char <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, dig[idx]};
      last_char  <= at_last;
    end
    if (load) begin
      for (int i = 0; i < SHOWN; i++) begin
        dig[i] <= bcd[i*DIGIT_W +: DIGIT_W];
      end
      idx <= top_idx;
    end else if (emit) begin
      idx <= idx - 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ verif/binary_to_decimal_ascii_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module binary_to_decimal_ascii_tb;
  import b2d_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_char;
  } text_char_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    string              text;
  } number_row_t;

  localparam int ITEM_COUNT  = 430;
  localparam int SHOW_ERRORS = 10;

  logic clk;
  logic rst;
  bit   calm;
  int   errors;
  int   sent;

  text_char_t expected_text[$];

  b2d_value_if number_bus ();
  b2d_char_if  text_bus ();

  binary_to_decimal_ascii u_dut (
    .clk    (clk),
    .rst    (rst),
    .number (number_bus),
    .text   (text_bus)
  );

  // empty text means the row is checked against the digit predictor
  number_row_t directed_rows[] = '{
    '{32'd0,          "0"},
    '{32'd1,          "1"},
    '{32'd9,          "9"},
    '{32'd10,         "10"},
    '{32'hFFFF_FFFF,  "4294967295"},
    '{32'd1000000000, "1000000000"},
    '{32'd999999999,  "999999999"},
    '{32'd2147483648, "2147483648"},
    '{32'd100,        ""},
    '{32'd99,         ""},
    '{32'd1234567890, ""},
    '{32'h5555_5555,  ""},
    '{32'hAAAA_AAAA,  ""},
    '{32'd4000000000, ""},
    '{32'd100000,     ""},
    '{32'd7,          ""}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // decimal digits, most significant first, leading zeros dropped
  function automatic void predict_text(input logic [VALUE_W-1:0] v);
    longint unsigned rest;
    longint unsigned scale;
    longint unsigned q;
    int              digs[MAX_DIGITS_DEF];
    int              n;
    bit              lead;
    text_char_t      c;
    rest  = v;
    scale = 1;
    n     = 0;
    lead  = 1'b0;
    for (int k = 1; k < MAX_DIGITS_DEF; k++) scale *= 10;
    for (int pos = MAX_DIGITS_DEF; pos > 0; pos--) begin
      q = rest / scale;
      if (q > 9) q = q % 10;
      if (q != 0) lead = 1'b1;
      if (lead) begin
        digs[n] = int'(q);
        n++;
      end
      rest = rest % scale;
      if (scale >= 10) scale = scale / 10;
    end
    if (n == 0) begin
      digs[0] = 0;
      n = 1;
    end
    for (int i = 0; i < n; i++) begin
      c.digit_char = ASCII_ZERO + CHAR_W'(digs[i]);
      c.last_char  = (i == n - 1);
      expected_text.push_back(c);
    end
  endfunction

  function automatic void expect_string(input string s);
    logic [7:0] b;
    text_char_t c;
    for (int i = 0; i < s.len(); i++) begin
      b            = s[i];
      c.digit_char = b[CHAR_W-1:0];
      c.last_char  = (i == s.len() - 1);
      expected_text.push_back(c);
    end
  endfunction

  // pick a digit count first so that short and long numbers are equally common
  function automatic logic [VALUE_W-1:0] random_number();
    longint unsigned lo;
    longint unsigned hi;
    int              digits;
    int              kind;
    kind = $urandom_range(15);
    if (kind == 0) return $urandom;
    if (kind == 1) return '0;
    digits = $urandom_range(1, MAX_DIGITS_DEF);
    lo = 1;
    for (int k = 1; k < digits; k++) lo *= 10;
    hi = lo * 10 - 1;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    if (digits == 1) lo = 0;
    if (kind == 2) return VALUE_W'(lo);
    if (kind == 3) return VALUE_W'(hi);
    return VALUE_W'(lo + (longint'($urandom) % (hi - lo + 1)));
  endfunction

  // valid stays high from one number to the next unless a gap is drawn
  task automatic send_number(input logic [VALUE_W-1:0] v, input string text);
    while (!calm && $urandom_range(99) < 16) begin
      number_bus.valid <= 1'b0;
      @(posedge clk);
    end
    number_bus.valid <= 1'b1;
    number_bus.value <= v;
    do @(posedge clk); while (!number_bus.ready);
    if (text.len() != 0) expect_string(text);
    else predict_text(v);
    sent++;
  endtask

  task automatic drain_text();
    number_bus.valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      text_bus.ready <= 1'b0;
    end else begin
      text_bus.ready <= calm || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin
    text_char_t got;
    text_char_t want;
    if (!rst && text_bus.valid && text_bus.ready) begin
      got.digit_char = text_bus.digit_char;
      got.last_char  = text_bus.last_char;
      if (expected_text.size() == 0) begin
        errors++;
        if (errors <= SHOW_ERRORS)
          $display("unexpected char transfer: digit_char=%0d last_char=%0b",
                   got.digit_char, got.last_char);
      end else begin
        want = expected_text.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= SHOW_ERRORS)
            $display("char mismatch: expected digit_char=%0d last_char=%0b, got %0d %0b",
                     want.digit_char, want.last_char, got.digit_char, got.last_char);
        end
      end
    end
  end

  initial begin
    errors = 0;
    sent   = 0;
    calm   = 1'b0;
    rst    <= 1'b1;
    number_bus.valid <= 1'b0;
    number_bus.value <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) send_number(directed_rows[i].value, directed_rows[i].text);
    drain_text();

    while (sent < ITEM_COUNT) begin
      calm = (sent >= 250 && sent < 330);
      if (sent == 200) drain_text();
      send_number(random_number(), "");
    end
    calm = 1'b0;
    number_bus.valid <= 1'b0;

    while (expected_text.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (errors == 0 && expected_text.size() == 0) begin
      $display("tb: success");
    end else begin
      if (expected_text.size() != 0)
        $display("%0d expected chars never arrived", expected_text.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
